### rtl/lifo_stack_with_status_defines.svh
// Assertion macros shared by the stack RTL.
`ifndef LIFO_STACK_WITH_STATUS_DEFINES_SVH
`define LIFO_STACK_WITH_STATUS_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define LSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define LSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LSS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LSS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/lss_pkg.sv
// Shared types and constants for the LIFO stack.
package lss_pkg;

    localparam logic [2:0] FUNC_PEEK  = 3'd0;
    localparam logic [2:0] FUNC_PUSH  = 3'd1;
    localparam logic [2:0] FUNC_POP   = 3'd2;
    localparam logic [2:0] FUNC_DROP  = 3'd3;
    localparam logic [2:0] FUNC_CLEAR = 3'd4;

    localparam logic [1:0] STAT_EMPTY  = 2'd0;
    localparam logic [1:0] STAT_ONE    = 2'd1;
    localparam logic [1:0] STAT_NORMAL = 2'd2;
    localparam logic [1:0] STAT_OVER   = 2'd3;

    localparam int         APB_AW          = 3;
    localparam logic       REG_DEPTH_IDX   = 1'b0;
    localparam logic [6:0] DEPTH_IN_USE_RST = 7'd64;

    typedef struct packed {
        logic capture;
        logic exec;
    } lss_cmd_t;

endpackage

### rtl/lifo_stack_with_status.sv
// LIFO data stack of 16-bit words with empty/one/normal/overflow status.
// Each transaction (peek, push, pop, drop, clear) runs as a capture step, with the
// registered read of the top entry from the stack memory, then an execute step to
// update pointer, status and memory and load the result. A new transaction is
// accepted once the previous result has been taken or is taken in the same cycle,
// and not while one is executing. The memory is not cleared at reset; only entries
// that were pushed are ever returned.
`include "lifo_stack_with_status_defines.svh"

module lifo_stack_with_status
    import lss_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        func,
    input  logic [15:0]       push_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       top_value,
    output logic [1:0]        stack_status,
    output logic [5:0]        top_index
);

    lss_cmd_t   cmd;
    logic       cfg_we;
    logic [6:0] depth_in_use;
    logic       status_low;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_DEPTH_IDX);
    assign prdata = (paddr[2] == REG_DEPTH_IDX) ? {25'd0, depth_in_use} : 32'd0;

    lss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    lss_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (func),
        .push_value   (push_value),
        .cfg_we       (cfg_we),
        .cfg_wdata    (pwdata[6:0]),
        .depth_in_use (depth_in_use),
        .top_value    (top_value),
        .stack_status (stack_status),
        .top_index    (top_index)
    );

    assign status_low = (stack_status == STAT_EMPTY) || (stack_status == STAT_ONE);

    `LSS_ASSERT_NXT(a_accept_clears_out, clk, rst_n, in_valid && in_ready, !out_valid)
    `LSS_ASSERT_NXT(a_exec_gives_out, clk, rst_n, in_valid && in_ready, ##1 out_valid)
    `LSS_ASSERT_IMP(a_low_status_idx0, clk, rst_n, status_low, top_index == 6'd0)

endmodule

### rtl/lss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lss_ctrl.sv
// Transaction controller: input capture, execute step and output valid.
module lss_ctrl
    import lss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output lss_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    assign in_ready    = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign cmd.capture = in_valid && in_ready;
    assign cmd.exec    = (state_reg == S_EXEC);
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/lss_dp.sv
// Stack datapath: pointer, status, depth register and entry memory.
module lss_dp
    import lss_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  lss_cmd_t    cmd,
    input  logic [2:0]  func,
    input  logic [15:0] push_value,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    output logic [6:0]  depth_in_use,
    output logic [15:0] top_value,
    output logic [1:0]  stack_status,
    output logic [5:0]  top_index
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = (PW + 1 > 7) ? PW + 1 : 7;
    localparam int IDXW = 6;

    logic [2:0]    func_reg;
    logic [15:0]   value_reg;
    logic [6:0]    depth_reg;
    logic [PW-1:0] top_ptr_reg, top_ptr_next;
    logic [1:0]    status_reg, status_next;
    logic [15:0]   top_value_reg, top_value_next;

    logic [15:0]   rdata;
    logic [15:0]   top_word;
    logic [CW-1:0] depth_ext;
    logic [CW-1:0] cap;
    logic          room;
    logic          we;
    logic [PW-1:0] waddr;
    logic [IDXW+PW-1:0] idx_ext;

    lss_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (value_reg),
        .re    (cmd.capture),
        .raddr (top_ptr_reg),
        .rdata (rdata)
    );

    assign depth_ext = CW'(depth_reg);
    assign cap = (depth_reg == 7'd0)     ? CW'(1) :
                 (depth_ext > CW'(DEPTH)) ? CW'(DEPTH) : depth_ext;
    assign room = (CW'(top_ptr_reg) + CW'(1)) < cap;
    assign top_word = (status_reg == STAT_EMPTY) ? 16'd0 : rdata;

    always_comb
    begin
        top_ptr_next   = top_ptr_reg;
        status_next    = status_reg;
        top_value_next = 16'd0;
        we             = 1'b0;
        waddr          = top_ptr_reg;
        unique case (func_reg)
            FUNC_PEEK:
            begin
                top_value_next = top_word;
            end
            FUNC_PUSH:
            begin
                if (!room)
                begin
                    status_next = STAT_OVER;
                end
                else if (status_reg == STAT_EMPTY)
                begin
                    status_next = STAT_ONE;
                    we          = 1'b1;
                end
                else
                begin
                    status_next  = STAT_NORMAL;
                    top_ptr_next = top_ptr_reg + PW'(1);
                    waddr        = top_ptr_reg + PW'(1);
                    we           = 1'b1;
                end
            end
            FUNC_POP, FUNC_DROP:
            begin
                if (func_reg == FUNC_POP)
                begin
                    top_value_next = top_word;
                end
                if (status_reg != STAT_EMPTY)
                begin
                    if (top_ptr_reg == '0)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        status_next  = (top_ptr_reg == PW'(1)) ? STAT_ONE : STAT_NORMAL;
                        top_ptr_next = top_ptr_reg - PW'(1);
                    end
                end
            end
            FUNC_CLEAR:
            begin
                top_ptr_next = '0;
                status_next  = STAT_EMPTY;
            end
            default:
            begin
                top_value_next = 16'd0;
            end
        endcase
        if (!cmd.exec)
        begin
            we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            value_reg <= push_value;
        end
        if (cmd.exec)
        begin
            top_value_reg <= top_value_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_ptr_reg <= '0;
            status_reg  <= STAT_EMPTY;
            depth_reg   <= DEPTH_IN_USE_RST;
        end
        else
        begin
            if (cmd.exec)
            begin
                top_ptr_reg <= top_ptr_next;
                status_reg  <= status_next;
            end
            if (cfg_we)
            begin
                depth_reg <= cfg_wdata;
            end
        end
    end

    assign idx_ext      = {{IDXW{1'b0}}, top_ptr_reg};
    assign top_index    = idx_ext[IDXW-1:0];
    assign stack_status = status_reg;
    assign top_value    = top_value_reg;
    assign depth_in_use = depth_reg;

endmodule
